[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, character codes and the control store of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// character codes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam int         TAB_STEP = 8;

	localparam logic [7:0] ATTR_RESET = 8'd15;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} tcw_item_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] cell_data;
	} tcw_result_t;

	// microprogram step addresses
	typedef logic [3:0] step_t;
	localparam step_t S_IDLE  = 4'd0;
	localparam step_t S_PUT   = 4'd1;
	localparam step_t S_FIN   = 4'd2;
	localparam step_t S_RD    = 4'd3;
	localparam step_t S_RDW   = 4'd4;
	localparam step_t S_CLR   = 4'd5;
	localparam step_t S_COPY  = 4'd6;
	localparam step_t S_DRAIN = 4'd7;
	localparam step_t S_BLANK = 4'd8;

	typedef enum logic [2:0] {
		JM_NEXT      = 3'd0,
		JM_GOTO      = 3'd1,
		JM_DISPATCH  = 3'd2,
		JM_IF_SCROLL = 3'd3,
		JM_UNTIL_CPY = 3'd4,
		JM_UNTIL_ALL = 3'd5
	} jump_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_CLR  = 2'd1,
		CNT_INC  = 2'd2
	} cnt_op_t;

	typedef enum logic [1:0] {
		WE_NONE   = 2'd0,
		WE_PRINT  = 2'd1,
		WE_ALWAYS = 2'd2
	} we_op_t;

	typedef enum logic [0:0] {
		WA_CURSOR = 1'b0,
		WA_CNT    = 1'b1
	} wa_sel_t;

	typedef enum logic [0:0] {
		WD_CHAR  = 1'b0,
		WD_BLANK = 1'b1
	} wd_sel_t;

	typedef enum logic [0:0] {
		RA_INDEX = 1'b0,
		RA_COPY  = 1'b1
	} ra_sel_t;

	typedef enum logic [1:0] {
		CUR_HOLD = 2'd0,
		CUR_PUT  = 2'd1,
		CUR_HOME = 2'd2
	} cur_op_t;

	typedef enum logic [1:0] {
		DAT_HOLD = 2'd0,
		DAT_CLR  = 2'd1,
		DAT_LOAD = 2'd2
	} dat_op_t;

	typedef struct packed {
		jump_t   jm;
		step_t   target;
		cnt_op_t cnt_op;
		we_op_t  we;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		ra_sel_t ra_sel;
		logic    copy;
		cur_op_t cur_op;
		dat_op_t dat_op;
		logic    emit;
	} ucode_t;

	// condition flags from the datapath
	typedef struct packed {
		logic       start;
		logic [1:0] cmd;
		logic       scroll;
		logic       copy_last;
		logic       all_last;
	} seq_status_t;

	function automatic step_t dispatch_target(input logic [1:0] cmd);
		step_t t;
		unique case (cmd)
			CMD_PUT:   t = S_PUT;
			CMD_CLEAR: t = S_CLR;
			CMD_READ:  t = S_RD;
			default:   t = S_FIN;
		endcase
		return t;
	endfunction

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		w = '{jm: JM_GOTO, target: S_IDLE, cnt_op: CNT_HOLD, we: WE_NONE,
			wa_sel: WA_CURSOR, wd_sel: WD_CHAR, ra_sel: RA_INDEX, copy: 1'b0,
			cur_op: CUR_HOLD, dat_op: DAT_HOLD, emit: 1'b0};
		unique case (pc)
			S_IDLE: begin
				w.jm     = JM_DISPATCH;
				w.cnt_op = CNT_CLR;
				w.dat_op = DAT_CLR;
			end
			S_PUT: begin
				w.jm     = JM_IF_SCROLL;
				w.target = S_COPY;
				w.we     = WE_PRINT;
				w.cur_op = CUR_PUT;
			end
			S_FIN: begin
				w.target = S_IDLE;
				w.emit   = 1'b1;
			end
			S_RD: begin
				w.jm = JM_NEXT;
			end
			S_RDW: begin
				w.target = S_FIN;
				w.dat_op = DAT_LOAD;
			end
			S_CLR: begin
				w.target = S_BLANK;
				w.cur_op = CUR_HOME;
			end
			S_COPY: begin
				w.jm     = JM_UNTIL_CPY;
				w.target = S_DRAIN;
				w.ra_sel = RA_COPY;
				w.copy   = 1'b1;
				w.cnt_op = CNT_INC;
			end
			S_DRAIN: begin
				w.jm = JM_NEXT;
			end
			S_BLANK: begin
				w.jm     = JM_UNTIL_ALL;
				w.target = S_FIN;
				w.we     = WE_ALWAYS;
				w.wa_sel = WA_CNT;
				w.wd_sel = WD_BLANK;
				w.cnt_op = CNT_INC;
			end
			default: begin
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/core/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/tcw_sequencer.sv]
// ----------------------------------------------------------------------------
// tcw_sequencer
// Step counter and control store; jumps on datapath flags.
// ----------------------------------------------------------------------------
module tcw_sequencer import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ucode_t      cw,
	output logic        busy
);

	step_t pc_q;
	step_t pc_next;

	assign cw   = ucode_rom(pc_q);
	assign busy = (pc_q != S_IDLE);

	always_comb begin
		unique case (cw.jm)
			JM_NEXT:      pc_next = pc_q + step_t'(1);
			JM_GOTO:      pc_next = cw.target;
			JM_DISPATCH:  pc_next = status.start ? dispatch_target(status.cmd) : pc_q;
			JM_IF_SCROLL: pc_next = status.scroll ? cw.target : pc_q + step_t'(1);
			JM_UNTIL_CPY: pc_next = status.copy_last ? cw.target : pc_q;
			JM_UNTIL_ALL: pc_next = status.all_last ? cw.target : pc_q;
			default:      pc_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

[rtl/core/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console writer: put character, clear screen, read cell, with scroll.
// ----------------------------------------------------------------------------
//  channel   signals                 direction  handshake
//  command   start, busy, item       in         taken when start && !busy
//  result    done, result            out        one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data        in         written when cfg_we
//
//  Put without scroll: steps S_PUT then S_FIN; unused command: S_FIN only.
//  Read: S_RD, S_RDW, S_FIN; S_RD is spent on the registered screen RAM read.
//  Scroll: copy of ROWS-1 rows one cell per cycle plus a blank row,
//  then S_DRAIN, the blank row and S_FIN; clear: S_CLR, a full blank sweep.
//  The screen RAM's single write port sets the sweep length.
//  Reset homes the cursor and sets the attribute to 15; screen contents are
//  undefined until cleared or written. busy drops the cycle done rises.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  tcw_item_t   item,
	output logic        done,
	output tcw_result_t result,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data
);

	localparam int CELLS     = ROWS * COLUMNS;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int RX_W      = $clog2(ROWS + 1);
	localparam int COPY_LAST = (ROWS - 1) * COLUMNS - 1;
	localparam int ALL_LAST  = CELLS - 1;

	ucode_t      cw;
	seq_status_t status;

	logic [7:0]        attr_q;
	logic [7:0]        char_q;
	logic [10:0]       idx_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] cnt_q;
	logic [15:0]       data_q;
	logic              done_q;
	tcw_result_t       result_q;
	logic              copy_s1;
	logic [CELL_W-1:0] wa_s1;

	logic              accept;
	logic [COL_W:0]    col_x;
	logic [COL_W:0]    col_n;
	logic [COL_W:0]    tab_sum;
	logic              row_inc;
	logic [RX_W-1:0]   row_n;
	logic              put_scroll;
	logic              printable;
	logic [CELL_W-1:0] pos;
	logic [11:0]       pos_ext;
	logic [12:0]       idx_ext;
	logic              in_range;

	logic              ram_we;
	logic [CELL_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [CELL_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	assign accept = start && !busy;

	// cursor rules for the held character
	always_comb begin
		col_x   = {1'b0, col_q};
		col_n   = col_x;
		row_inc = 1'b0;
		tab_sum = col_x + (COL_W + 1)'(TAB_STEP);
		case (char_q)
			CH_BS: begin
				if (col_q != '0) col_n = col_x - (COL_W + 1)'(1);
			end
			CH_TAB: col_n = {tab_sum[COL_W:3], 3'b000};
			CH_CR:  col_n = '0;
			CH_LF: begin
				col_n   = '0;
				row_inc = 1'b1;
			end
			default: begin
				if (char_q >= CH_SPACE) col_n = col_x + (COL_W + 1)'(1);
			end
		endcase
		if (col_n >= (COL_W + 1)'(COLUMNS)) begin
			col_n   = '0;
			row_inc = 1'b1;
		end
		row_n      = RX_W'(row_q) + RX_W'(row_inc);
		put_scroll = (row_n == RX_W'(ROWS));
	end

	assign printable = (char_q >= CH_SPACE);
	assign pos       = CELL_W'(row_q) * CELL_W'(COLUMNS) + CELL_W'(col_q);
	assign pos_ext   = 12'(pos);
	assign idx_ext   = {2'b00, idx_q};
	assign in_range  = (idx_ext < 13'(CELLS));

	assign status.start     = start;
	assign status.cmd       = item.cmd;
	assign status.scroll    = put_scroll;
	assign status.copy_last = (cnt_q == CELL_W'(COPY_LAST));
	assign status.all_last  = (cnt_q == CELL_W'(ALL_LAST));

	tcw_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw),
		.busy   (busy)
	);

	// single write port: a pending row-copy beat owns it
	always_comb begin
		if (copy_s1) begin
			ram_we    = 1'b1;
			ram_waddr = wa_s1;
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = (cw.we == WE_ALWAYS) || ((cw.we == WE_PRINT) && printable);
			ram_waddr = (cw.wa_sel == WA_CNT) ? cnt_q : pos;
			ram_wdata = (cw.wd_sel == WD_BLANK) ? {attr_q, CH_SPACE} : {attr_q, char_q};
		end
		ram_raddr = (cw.ra_sel == RA_COPY) ? cnt_q + CELL_W'(COLUMNS) : idx_ext[CELL_W-1:0];
	end

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= ATTR_RESET;
			col_q   <= '0;
			row_q   <= '0;
			done_q  <= 1'b0;
			copy_s1 <= 1'b0;
		end else begin
			if (cfg_we) attr_q <= cfg_data;
			case (cw.cur_op)
				CUR_PUT: begin
					col_q <= col_n[COL_W-1:0];
					row_q <= put_scroll ? ROW_W'(ROWS - 1) : row_n[ROW_W-1:0];
				end
				CUR_HOME: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
			done_q  <= cw.emit;
			copy_s1 <= cw.copy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= item.char_code;
			idx_q  <= item.cell_index;
		end
		case (cw.cnt_op)
			CNT_CLR: cnt_q <= '0;
			CNT_INC: cnt_q <= cnt_q + CELL_W'(1);
			default: ;
		endcase
		case (cw.dat_op)
			DAT_CLR:  data_q <= '0;
			DAT_LOAD: data_q <= in_range ? ram_rdata : 16'd0;
			default: ;
		endcase
		wa_s1 <= cnt_q;
		if (cw.emit) begin
			result_q.cursor_pos <= pos_ext[10:0];
			result_q.cell_data  <= data_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		copy_s1 |-> (cw.we == WE_NONE))
		else $error("copy beat collides with a sequencer write");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < (COL_W + 1)'(COLUMNS)) && ({1'b0, row_q} < (ROW_W + 1)'(ROWS)))
		else $error("cursor outside the screen");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after a command was taken");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && !$past(done))
		else $error("result strobe while busy or longer than one cycle");

endmodule
